### design/srsr_pkg.sv
// ----------------------------------------------------------------------------
// SMTP reply status reader package
// Shared widths, character codes and types for the reply status reader.
// ----------------------------------------------------------------------------
package srsr_pkg;

   localparam int HEAD_LEN    = 4;
   localparam int CODE_LEN    = 3;
   localparam int COUNT_W     = $clog2(HEAD_LEN + 1);
   localparam int TICK_W      = 21;
   localparam int TIMEOUT_W   = 20;
   localparam int STATUS_W    = 11;
   localparam int VALUE_W     = 10;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);
   localparam logic [TICK_W-1:0]    TICK_MAX      = {TICK_W{1'b1}};

   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_PLUS  = 8'h2B;
   localparam logic [7:0] BYTE_DASH  = 8'h2D;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   typedef logic [HEAD_LEN-1:0][7:0] head_type;
   typedef logic [CODE_LEN-1:0][7:0] code_bytes_type;

endpackage

### design/srsr_code_decode.sv
// ----------------------------------------------------------------------------
// Reply code decoder
// Converts the first three bytes of a reply line into a signed number in the
// manner of atoi: leading whitespace, one optional sign, then decimal digits.
// ----------------------------------------------------------------------------
module srsr_code_decode (
   input  srsr_pkg::code_bytes_type              code_bytes,
   output logic signed [srsr_pkg::STATUS_W-1:0]  code_value
);

   function automatic logic is_blank(input logic [7:0] b);
      return (b == srsr_pkg::BYTE_SPACE) ||
             ((b >= srsr_pkg::BYTE_TAB) && (b <= srsr_pkg::BYTE_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= srsr_pkg::BYTE_ZERO) && (b <= srsr_pkg::BYTE_NINE);
   endfunction

   logic                          lead;
   logic                          done;
   logic                          neg;
   logic [srsr_pkg::VALUE_W-1:0]  value;
   logic [7:0]                    digit;

   always_comb begin
      lead  = 1'b1;
      done  = 1'b0;
      neg   = 1'b0;
      value = '0;
      digit = '0;
      for (int k = 0; k < srsr_pkg::CODE_LEN; k++) begin
         digit = code_bytes[k] - srsr_pkg::BYTE_ZERO;
         if (!done) begin
            if (lead && is_blank(code_bytes[k])) begin
               lead = 1'b1;
            end else if (lead && ((code_bytes[k] == srsr_pkg::BYTE_PLUS) ||
                                  (code_bytes[k] == srsr_pkg::BYTE_DASH))) begin
               neg  = (code_bytes[k] == srsr_pkg::BYTE_DASH);
               lead = 1'b0;
            end else if (is_digit(code_bytes[k])) begin
               value = srsr_pkg::VALUE_W'(value * 4'd10) + srsr_pkg::VALUE_W'(digit[3:0]);
               lead  = 1'b0;
            end else begin
               done = 1'b1;
            end
         end
      end
      code_value = neg ? -$signed({1'b0, value}) : $signed({1'b0, value});
   end

endmodule

### design/smtp_reply_status_reader.sv
// ----------------------------------------------------------------------------
// SMTP reply status reader
// Follows the lines of one SMTP server reply byte by byte and reports the
// status code of the final line, or a timeout when a line takes too long.
//
//   Channel   Direction  Ports                                  Transaction
//   req       in         req_valid/ready, req_type, req_rx_byte  byte, tick, start
//   rsp       out        rsp_valid/ready, rsp_status_code,       one reply result
//                        rsp_timed_out
//   csr       in         csr_wr_en, csr_wr_data                  timeout limit
//
// One request transaction can be taken every cycle while req_ready is high.
// Its result, if any, appears on the response port in the following cycle.
// The response register holds while rsp_ready is low; requests still flow then
// as long as the register is free or is being emptied in the same cycle.
// Reset is synchronous and leaves the block disarmed with a limit of 10000.
// ----------------------------------------------------------------------------
module smtp_reply_status_reader (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_type,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [srsr_pkg::STATUS_W-1:0]  rsp_status_code,
   output logic                                  rsp_timed_out,
   input  logic                                  csr_wr_en,
   input  logic [srsr_pkg::TIMEOUT_W-1:0]        csr_wr_data
);

   logic [srsr_pkg::TIMEOUT_W-1:0]       timeout_ff;
   logic                                 armed_ff, armed_in;
   logic                                 saw_cr_ff, saw_cr_in;
   logic [srsr_pkg::COUNT_W-1:0]         byte_count_ff, byte_count_in;
   logic [srsr_pkg::TICK_W-1:0]          tick_count_ff, tick_count_in;
   srsr_pkg::head_type                   head_ff, head_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [srsr_pkg::STATUS_W-1:0] rsp_status_code_ff, rsp_status_code_in;
   logic                                 rsp_timed_out_ff, rsp_timed_out_in;

   logic                                 req_fire;
   logic                                 result_take;
   logic [srsr_pkg::TICK_W-1:0]          tick_next;
   logic signed [srsr_pkg::STATUS_W-1:0] code_value;

   assign req_ready       = !rsp_valid_ff || rsp_ready;
   assign req_fire        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_code = rsp_status_code_ff;
   assign rsp_timed_out   = rsp_timed_out_ff;

   srsr_code_decode u_code_decode (
      .code_bytes (head_in[srsr_pkg::CODE_LEN-1:0]),
      .code_value (code_value)
   );

   always_comb begin
      armed_in           = armed_ff;
      saw_cr_in          = saw_cr_ff;
      byte_count_in      = byte_count_ff;
      tick_count_in      = tick_count_ff;
      head_in            = head_ff;
      result_take        = 1'b0;
      rsp_status_code_in = '0;
      rsp_timed_out_in   = 1'b0;
      tick_next          = (tick_count_ff == srsr_pkg::TICK_MAX) ? tick_count_ff
                                                                 : tick_count_ff + 1'b1;
      if (req_valid && (req_type == srsr_pkg::KIND_BYTE) &&
          (byte_count_ff < srsr_pkg::COUNT_W'(srsr_pkg::HEAD_LEN))) begin
         head_in[byte_count_ff[$clog2(srsr_pkg::HEAD_LEN)-1:0]] = req_rx_byte;
      end
      if (req_fire) begin
         unique case (req_type)
            srsr_pkg::KIND_START: begin
               armed_in      = 1'b1;
               saw_cr_in     = 1'b0;
               byte_count_in = '0;
               tick_count_in = '0;
            end
            srsr_pkg::KIND_TICK: begin
               if (armed_ff) begin
                  tick_count_in = tick_next;
                  if (tick_next > {1'b0, timeout_ff}) begin
                     armed_in         = 1'b0;
                     saw_cr_in        = 1'b0;
                     byte_count_in    = '0;
                     tick_count_in    = '0;
                     result_take      = 1'b1;
                     rsp_timed_out_in = 1'b1;
                  end
               end
            end
            srsr_pkg::KIND_BYTE: begin
               if (armed_ff) begin
                  if (byte_count_ff < srsr_pkg::COUNT_W'(srsr_pkg::HEAD_LEN)) begin
                     byte_count_in = byte_count_ff + 1'b1;
                  end
                  if (saw_cr_ff && (req_rx_byte == srsr_pkg::BYTE_LF)) begin
                     saw_cr_in     = 1'b0;
                     tick_count_in = '0;
                     if (!((byte_count_in >= srsr_pkg::COUNT_W'(srsr_pkg::HEAD_LEN)) &&
                           (head_in[srsr_pkg::HEAD_LEN-1] == srsr_pkg::BYTE_DASH))) begin
                        armed_in    = 1'b0;
                        result_take = 1'b1;
                        if (byte_count_in >= srsr_pkg::COUNT_W'(srsr_pkg::CODE_LEN)) begin
                           rsp_status_code_in = code_value;
                        end
                     end
                     byte_count_in = '0;
                  end else begin
                     saw_cr_in = (req_rx_byte == srsr_pkg::BYTE_CR);
                  end
               end
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire && result_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= srsr_pkg::TIMEOUT_RESET;
         armed_ff      <= 1'b0;
         saw_cr_ff     <= 1'b0;
         byte_count_ff <= '0;
         tick_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         armed_ff      <= armed_in;
         saw_cr_ff     <= saw_cr_in;
         byte_count_ff <= byte_count_in;
         tick_count_ff <= tick_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && armed_ff && (req_type == srsr_pkg::KIND_BYTE)) begin
         head_ff <= head_in;
      end
      if (req_fire && result_take) begin
         rsp_status_code_ff <= rsp_status_code_in;
         rsp_timed_out_ff   <= rsp_timed_out_in;
      end
   end

   // A timeout always reports a zero status code.
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_timed_out) |-> (rsp_status_code == '0))
      else $error("timeout response carries a nonzero status code");

   // Producing a result disarms the reader.
   a_result_disarms: assert property (@(posedge clock) disable iff (reset)
      (req_fire && result_take) |=> !armed_ff)
      else $error("reader still armed after a result");

   // The line byte count never goes past the kept head length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= srsr_pkg::COUNT_W'(srsr_pkg::HEAD_LEN))
      else $error("byte count beyond head length");

   // A response is never overwritten before it is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(req_fire && result_take))
      else $error("pending response overwritten");

endmodule
